// ===== rtl/core/lcdseq_pkg.sv =====
// Shared types, constants and sequence tables for the LCD command sequencer.
`default_nettype none

package lcdseq_pkg;

  // Command codes carried in the operation field.
  typedef enum logic [2:0] {
    OP_INIT     = 3'd0,
    OP_CLEAR    = 3'd1,
    OP_HOME     = 3'd2,
    OP_POS      = 3'd3,
    OP_CHAR     = 3'd4,
    OP_RAW_BYTE = 3'd5,
    OP_RAW_NIB  = 3'd6,
    OP_NONE     = 3'd7
  } op_e;

  localparam int unsigned WaitW   = 19;
  localparam int unsigned InitLen = 12;
  localparam int unsigned IdxW    = $clog2(InitLen);

  localparam logic [WaitW-1:0] WaitClear = 19'd2000;
  localparam logic [WaitW-1:0] WaitHome  = 19'd1600;
  localparam logic [WaitW-1:0] WaitShort = 19'd40;

  localparam logic [7:0] CmdClear  = 8'h01;
  localparam logic [7:0] CmdHome   = 8'h02;
  localparam logic [7:0] CmdSetPos = 8'h80;

  // One accepted command word.
  typedef struct packed {
    op_e              operation;
    logic             rs;
    logic [7:0]       value;
    logic [1:0]       row;
    logic [6:0]       col;
    logic [WaitW-1:0] delay_us;
  } cmd_t;

  // One nibble transfer on the LCD bus.
  typedef struct packed {
    logic             sel;
    logic [3:0]       nibble;
    logic [WaitW-1:0] wait_us;
    logic             last;
  } xfer_t;

  typedef struct packed {
    logic [3:0]       nibble;
    logic [WaitW-1:0] wait_us;
  } init_step_t;

  // Start address of each display row in display RAM.
  function automatic logic [6:0] row_base(input logic [1:0] row);
    logic [6:0] base;
    case (row)
      2'd0:    base = 7'h00;
      2'd1:    base = 7'h40;
      2'd2:    base = 7'h14;
      default: base = 7'h54;
    endcase
    return base;
  endfunction

  // Power-up sequence: three wake-up nibbles, switch to 4-bit mode, then
  // function set, display on, entry mode and clear, each high nibble first.
  function automatic init_step_t init_step(input logic [IdxW-1:0] idx);
    init_step_t s;
    case (idx)
      4'd0:    s = '{nibble: 4'h3, wait_us: 19'd4200};
      4'd1:    s = '{nibble: 4'h3, wait_us: 19'd100};
      4'd2:    s = '{nibble: 4'h3, wait_us: WaitShort};
      4'd3:    s = '{nibble: 4'h2, wait_us: WaitShort};
      4'd4:    s = '{nibble: 4'h2, wait_us: '0};
      4'd5:    s = '{nibble: 4'h8, wait_us: WaitShort};
      4'd6:    s = '{nibble: 4'h0, wait_us: '0};
      4'd7:    s = '{nibble: 4'hC, wait_us: WaitShort};
      4'd8:    s = '{nibble: 4'h0, wait_us: '0};
      4'd9:    s = '{nibble: 4'h6, wait_us: WaitShort};
      4'd10:   s = '{nibble: 4'h0, wait_us: '0};
      4'd11:   s = '{nibble: 4'h1, wait_us: WaitClear};
      default: s = '{nibble: 4'h0, wait_us: '0};
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lcd_4bit_command_sequencer_unit.sv =====
// Top level of the character LCD 4-bit command sequencer.
`default_nettype none

// Takes one LCD command word and sends out its run of 4-bit bus transfers,
// one word per cycle through a registered output stage. A command is held in
// the input register while its run is produced; the next command is taken in
// the cycle its last transfer moves to the output register. Clear, home,
// position, character and raw byte send two transfers, raw nibble one and init
// twelve, and the unused operation code is dropped with no output. A stall on
// the output holds the run and, once the input register is busy, the input.
module lcd_4bit_command_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic        rs_i,
  input  logic [7:0]  value_i,
  input  logic [1:0]  row_i,
  input  logic [6:0]  col_i,
  input  logic [18:0] delay_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        sel_o,
  output logic [3:0]  nibble_o,
  output logic [18:0] wait_us_o,
  output logic        last_o
);
  import lcdseq_pkg::*;

  cmd_t            cmd_q;
  logic            cmd_valid_q;
  logic [IdxW-1:0] idx_q;
  xfer_t           out_q;
  logic            out_valid_q;

  xfer_t xfer;
  logic  emit;
  logic  out_free;
  logic  step;
  logic  done;
  logic  in_accept;

  lcdseq_xfer_gen u_xfer_gen (
    .cmd_i  (cmd_q),
    .idx_i  (idx_q),
    .xfer_o (xfer),
    .emit_o (emit)
  );

  // A transfer advances when the output stage can take it; a dropped
  // command needs no room.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = cmd_valid_q && (!emit || out_free);
  assign done       = step && xfer.last;
  assign in_stall_o = cmd_valid_q && !done;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register and run position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (in_accept) begin
      cmd_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (done) begin
      cmd_valid_q <= 1'b0;
    end else if (step) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= '{operation: op_e'(operation_i), rs: rs_i, value: value_i,
                 row: row_i, col: col_i, delay_us: delay_us_i};
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_q <= xfer;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sel_o       = out_q.sel;
  assign nibble_o    = out_q.nibble;
  assign wait_us_o   = out_q.wait_us;
  assign last_o      = out_q.last;

`ifndef NO_ASSERTIONS
  // The run position never runs past the init table.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_q |-> idx_q <= IdxW'(InitLen - 1))
    else $error("run position beyond init sequence");

  // Commands other than init stop after at most two transfers.
  a_short_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_q && cmd_q.operation != OP_INIT) |-> idx_q <= IdxW'(1))
    else $error("short command run too long");

  // A new command is only taken once the held one has finished.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> (!cmd_valid_q || done))
    else $error("held command overwritten");

  // Finishing a run with no new command frees the input register.
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && !in_accept) |=> !cmd_valid_q)
    else $error("input register not released");

  // A stalled output word is not overwritten by the next transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !(step && emit))
    else $error("stalled output word overwritten");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/lcdseq_xfer_gen.sv =====
// Builds the nibble transfer at a given position of a command's run.
`default_nettype none

module lcdseq_xfer_gen (
  input  lcdseq_pkg::cmd_t              cmd_i,
  input  logic [lcdseq_pkg::IdxW-1:0]   idx_i,
  output lcdseq_pkg::xfer_t             xfer_o,
  output logic                          emit_o
);
  import lcdseq_pkg::*;

  logic [7:0]       byte_val;
  logic             byte_sel;
  logic [WaitW-1:0] byte_wait;
  logic [6:0]       pos_addr;
  init_step_t       init_s;

  assign pos_addr = row_base(cmd_i.row) + cmd_i.col;
  assign init_s   = init_step(idx_i);

  // Byte, register select and final wait for the two-nibble commands and raw nibble.
  always_comb begin
    byte_val  = cmd_i.value;
    byte_sel  = 1'b0;
    byte_wait = WaitShort;
    case (cmd_i.operation)
      OP_CLEAR: begin
        byte_val  = CmdClear;
        byte_wait = WaitClear;
      end
      OP_HOME: begin
        byte_val  = CmdHome;
        byte_wait = WaitHome;
      end
      OP_POS: begin
        byte_val = CmdSetPos | {1'b0, pos_addr};
      end
      OP_CHAR: begin
        byte_sel = 1'b1;
      end
      OP_RAW_BYTE, OP_RAW_NIB: begin
        byte_sel  = cmd_i.rs;
        byte_wait = cmd_i.delay_us;
      end
      default: begin
        byte_val = cmd_i.value;
      end
    endcase
  end

  // Pick the transfer: init walks its table, raw nibble is a single word,
  // other commands send the high nibble first and the low nibble last.
  always_comb begin
    emit_o = 1'b1;
    xfer_o = '0;
    case (cmd_i.operation)
      OP_INIT: begin
        xfer_o.nibble  = init_s.nibble;
        xfer_o.wait_us = init_s.wait_us;
        xfer_o.last    = (idx_i == IdxW'(InitLen - 1));
      end
      OP_RAW_NIB: begin
        xfer_o.sel     = byte_sel;
        xfer_o.nibble  = cmd_i.value[3:0];
        xfer_o.wait_us = byte_wait;
        xfer_o.last    = 1'b1;
      end
      OP_NONE: begin
        emit_o      = 1'b0;
        xfer_o.last = 1'b1;
      end
      default: begin
        xfer_o.sel     = byte_sel;
        xfer_o.nibble  = idx_i[0] ? byte_val[3:0] : byte_val[7:4];
        xfer_o.wait_us = idx_i[0] ? byte_wait : '0;
        xfer_o.last    = idx_i[0];
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for the LCD 4-bit command sequencer: random and directed commands, checked per transfer.
`timescale 1ns / 100ps

module tb_top;
  import lcdseq_pkg::*;

  localparam int unsigned NumRandomCmds = 350;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned HoldOffCycles = 80;
  localparam logic [WaitW-1:0] WaitWake    = 19'd4200;
  localparam logic [WaitW-1:0] WaitWake2   = 19'd100;
  localparam logic [WaitW-1:0] MaxDelay    = 19'h7FFFF;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [2:0]        operation_i = '0;
  logic              rs_i        = 1'b0;
  logic [7:0]        value_i     = '0;
  logic [1:0]        row_i       = '0;
  logic [6:0]        col_i       = '0;
  logic [WaitW-1:0]  delay_us_i  = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              sel_o;
  logic [3:0]        nibble_o;
  logic [WaitW-1:0]  wait_us_o;
  logic              last_o;

  // Commands waiting to be offered, and bus transfers predicted but not yet seen.
  cmd_t  pending_cmds[$];
  xfer_t expected_xfers[$];

  cmd_t  next_cmd;
  xfer_t seen_xfer;
  xfer_t want_xfer;
  logic  word_taken = 1'b0;
  logic  calm       = 1'b0;
  logic  hold_done  = 1'b0;
  int    hold_left  = 0;
  int    sent_cnt   = 0;
  int    errors     = 0;

  // Display RAM start address of each row.
  logic [6:0] row_start [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

  lcd_4bit_command_sequencer_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .rs_i        (rs_i),
    .value_i     (value_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .delay_us_i  (delay_us_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sel_o       (sel_o),
    .nibble_o    (nibble_o),
    .wait_us_o   (wait_us_o),
    .last_o      (last_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void queue_transfer(input logic sel, input logic [3:0] nib,
                                         input logic [WaitW-1:0] wt, input logic fin);
    xfer_t x;
    x.sel     = sel;
    x.nibble  = nib;
    x.wait_us = wt;
    x.last    = fin;
    expected_xfers.push_back(x);
  endfunction

  // A byte goes out high nibble first; only the low nibble carries the wait.
  function automatic void queue_byte(input logic sel, input logic [7:0] data,
                                     input logic [WaitW-1:0] wt, input logic fin);
    queue_transfer(sel, data[7:4], '0, 1'b0);
    queue_transfer(sel, data[3:0], wt, fin);
  endfunction

  // Expands one accepted command word into the bus transfers it should cause.
  function automatic void predict_transfers(input cmd_t c);
    logic [6:0] addr;
    case (c.operation)
      OP_INIT: begin
        queue_transfer(1'b0, 4'h3, WaitWake, 1'b0);
        queue_transfer(1'b0, 4'h3, WaitWake2, 1'b0);
        queue_transfer(1'b0, 4'h3, WaitShort, 1'b0);
        queue_transfer(1'b0, 4'h2, WaitShort, 1'b0);
        queue_byte(1'b0, 8'h28, WaitShort, 1'b0);
        queue_byte(1'b0, 8'h0C, WaitShort, 1'b0);
        queue_byte(1'b0, 8'h06, WaitShort, 1'b0);
        queue_byte(1'b0, CmdClear, WaitClear, 1'b1);
      end
      OP_CLEAR: queue_byte(1'b0, CmdClear, WaitClear, 1'b1);
      OP_HOME:  queue_byte(1'b0, CmdHome, WaitHome, 1'b1);
      OP_POS: begin
        // The 7-bit sum wraps modulo 128.
        addr = row_start[c.row] + c.col;
        queue_byte(1'b0, CmdSetPos | {1'b0, addr}, WaitShort, 1'b1);
      end
      OP_CHAR:     queue_byte(1'b1, c.value, WaitShort, 1'b1);
      OP_RAW_BYTE: queue_byte(c.rs, c.value, c.delay_us, 1'b1);
      OP_RAW_NIB:  queue_transfer(c.rs, c.value[3:0], c.delay_us, 1'b1);
      default: ;
    endcase
  endfunction

  function automatic cmd_t make_cmd(input op_e op, input logic rs, input logic [7:0] value,
                                    input logic [1:0] row, input logic [6:0] col,
                                    input logic [WaitW-1:0] delay);
    cmd_t c;
    c.operation = op;
    c.rs        = rs;
    c.value     = value;
    c.row       = row;
    c.col       = col;
    c.delay_us  = delay;
    return c;
  endfunction

  // Random command: mostly short commands, now and then init or the unused code.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      c.operation = OP_INIT;
    end else if (pick < 9) begin
      c.operation = OP_NONE;
    end else begin
      c.operation = op_e'($urandom_range(1, 6));
    end
    c.rs    = 1'($urandom_range(0, 1));
    c.value = 8'($urandom_range(0, 255));
    c.row   = 2'($urandom_range(0, 3));
    c.col   = 7'($urandom_range(0, 127));
    case ($urandom_range(0, 7))
      0:       c.delay_us = '0;
      1:       c.delay_us = MaxDelay;
      default: c.delay_us = WaitW'($urandom_range(0, 32'h7FFFF));
    endcase
    return c;
  endfunction

  // Sender: holds a stalled word, otherwise offers the next one or idles.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || word_taken) begin
      if (pending_cmds.size() != 0 && (calm || $urandom_range(0, 99) >= 30)) begin
        next_cmd = pending_cmds.pop_front();
        operation_i <= next_cmd.operation;
        rs_i        <= next_cmd.rs;
        value_i     <= next_cmd.value;
        row_i       <= next_cmd.row;
        col_i       <= next_cmd.col;
        delay_us_i  <= next_cmd.delay_us;
        in_valid_i  <= 1'b1;
        sent_cnt    <= sent_cnt + 1;
        calm        <= (sent_cnt >= 180 && sent_cnt < 260);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off so the block backs up into its input.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && sent_cnt >= 120) begin
      out_stall_i <= 1'b1;
      hold_left   <= HoldOffCycles;
      hold_done   <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < 30);
    end
  end

  // Monitor: predicts from each accepted command word and checks each transfer in order.
  always @(posedge clk_i) begin
    word_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_transfers(make_cmd(op_e'(operation_i), rs_i, value_i, row_i, col_i, delay_us_i));
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_xfer = '{sel: sel_o, nibble: nibble_o, wait_us: wait_us_o, last: last_o};
      if (expected_xfers.size() == 0) begin
        $display("%0t: unexpected transfer sel=%0b nibble=%h wait=%0d last=%0b",
                 $time, sel_o, nibble_o, wait_us_o, last_o);
        errors++;
      end else begin
        want_xfer = expected_xfers.pop_front();
        if (seen_xfer.sel !== want_xfer.sel) begin
          $display("%0t: sel expected %0b actual %0b", $time, want_xfer.sel, seen_xfer.sel);
          errors++;
        end
        if (seen_xfer.nibble !== want_xfer.nibble) begin
          $display("%0t: nibble expected %h actual %h", $time, want_xfer.nibble,
                   seen_xfer.nibble);
          errors++;
        end
        if (seen_xfer.wait_us !== want_xfer.wait_us) begin
          $display("%0t: wait_us expected %0d actual %0d", $time, want_xfer.wait_us,
                   seen_xfer.wait_us);
          errors++;
        end
        if (seen_xfer.last !== want_xfer.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want_xfer.last, seen_xfer.last);
          errors++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int useful;
    // Directed commands: every operation, row wrap, field extremes, the unused code.
    pending_cmds.push_back(make_cmd(OP_INIT, 1'b1, 8'hFF, 2'd3, 7'h7F, MaxDelay));
    pending_cmds.push_back(make_cmd(OP_CLEAR, 1'b0, 8'h00, 2'd0, 7'h00, '0));
    pending_cmds.push_back(make_cmd(OP_HOME, 1'b1, 8'hFF, 2'd3, 7'h7F, MaxDelay));
    pending_cmds.push_back(make_cmd(OP_POS, 1'b0, 8'h00, 2'd0, 7'h00, '0));
    pending_cmds.push_back(make_cmd(OP_POS, 1'b1, 8'hFF, 2'd1, 7'h7F, MaxDelay));
    pending_cmds.push_back(make_cmd(OP_POS, 1'b0, 8'h5A, 2'd2, 7'h6C, 19'd5));
    pending_cmds.push_back(make_cmd(OP_POS, 1'b0, 8'h00, 2'd3, 7'h7F, '0));
    pending_cmds.push_back(make_cmd(OP_POS, 1'b0, 8'h00, 2'd2, 7'h13, '0));
    pending_cmds.push_back(make_cmd(OP_CHAR, 1'b0, 8'h00, 2'd0, 7'h00, '0));
    pending_cmds.push_back(make_cmd(OP_CHAR, 1'b0, 8'hFF, 2'd3, 7'h7F, MaxDelay));
    pending_cmds.push_back(make_cmd(OP_RAW_BYTE, 1'b0, 8'h00, 2'd0, 7'h00, '0));
    pending_cmds.push_back(make_cmd(OP_RAW_BYTE, 1'b1, 8'hFF, 2'd3, 7'h7F, MaxDelay));
    pending_cmds.push_back(make_cmd(OP_RAW_BYTE, 1'b0, 8'hA5, 2'd1, 7'h2A, 19'd1));
    pending_cmds.push_back(make_cmd(OP_RAW_NIB, 1'b1, 8'hFA, 2'd3, 7'h7F, MaxDelay));
    pending_cmds.push_back(make_cmd(OP_RAW_NIB, 1'b0, 8'h05, 2'd0, 7'h00, '0));
    pending_cmds.push_back(make_cmd(OP_RAW_NIB, 1'b1, 8'h30, 2'd2, 7'h11, 19'h40000));
    pending_cmds.push_back(make_cmd(OP_NONE, 1'b1, 8'hFF, 2'd3, 7'h7F, MaxDelay));
    pending_cmds.push_back(make_cmd(OP_NONE, 1'b0, 8'h00, 2'd0, 7'h00, '0));
    pending_cmds.push_back(make_cmd(OP_INIT, 1'b0, 8'h00, 2'd0, 7'h00, '0));

    // Random commands; the unused code does not count toward the total.
    useful = 0;
    while (useful < NumRandomCmds) begin
      next_cmd = random_cmd();
      pending_cmds.push_back(next_cmd);
      if (next_cmd.operation != OP_NONE) useful++;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for every word to be taken, then for every predicted transfer.
    while (pending_cmds.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_xfers.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lcdseq_pkg.sv
rtl/core/lcdseq_xfer_gen.sv
rtl/core/lcd_4bit_command_sequencer_unit.sv
verif/tb_top.sv
